/* sv/sorted_priority_queue_unit_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* sv/spq_pkg.sv */
// Shared types and constants of the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_unit.
`default_nettype none

package spq_pkg;

	localparam int FIELD_W = 32;
	localparam logic [FIELD_W-1:0] NOTHING_WORD = '1;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// Per-beat control handed to every cell of the chain.
	typedef struct packed {
		logic enq;        // insert the new entry this cycle
		logic deq;        // shift everything one cell toward the head
		logic prev_keep;  // the neighbor toward the head keeps its entry
	} cell_ctl_t;

endpackage

`default_nettype wire

/* sv/spq_cell.sv */
// One storage cell of the sorted chain: an entry, its priority compare and
// the neighbor hand-off. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
	parameter int SW = 32
) (
	input  wire logic                             clk,
	input  wire spq_pkg::cell_ctl_t               ctl,
	input  wire logic                             occupied,
	input  wire logic [SW-1:0]                    new_data,
	input  wire logic signed [spq_pkg::FIELD_W-1:0] new_prio,
	input  wire logic [SW-1:0]                    prev_data,
	input  wire logic signed [spq_pkg::FIELD_W-1:0] prev_prio,
	input  wire logic [SW-1:0]                    next_data,
	input  wire logic signed [spq_pkg::FIELD_W-1:0] next_prio,
	output logic                                  keep,
	output logic [SW-1:0]                         data_q,
	output logic signed [spq_pkg::FIELD_W-1:0]    prio_q
);
	import spq_pkg::*;

	// An entry stays put when its priority is at least the new one, so
	// equal priorities keep arrival order.
	assign keep = occupied && (prio_q >= new_prio);

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (keep) begin
				data_q <= data_q;
				prio_q <= prio_q;
			end else if (ctl.prev_keep) begin
				data_q <= new_data;
				prio_q <= new_prio;
			end else begin
				data_q <= prev_data;
				prio_q <= prev_prio;
			end
		end else if (ctl.deq) begin
			data_q <= next_data;
			prio_q <= next_prio;
		end
	end

endmodule

`default_nettype wire

/* sv/sorted_priority_queue_unit.sv */
// Sorted priority queue: the result beat is strobed by done in the cycle right
// after start is taken. Throughput is one command per cycle, set by the per-cell
// priority compare and the one-step shift of the chain.
// busy is high while arst_n is asserted and clears at the next clock after release.
// Reset empties the queue; the slot contents stay undefined until written.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire spq_pkg::cmd_t                      cmd,
	input  wire logic signed [spq_pkg::FIELD_W-1:0] item_data,
	input  wire logic signed [spq_pkg::FIELD_W-1:0] item_priority,
	output logic                                    done,
	output logic signed [spq_pkg::FIELD_W-1:0]      removed_data,
	output logic                                    removed_valid,
	output logic signed [spq_pkg::FIELD_W-1:0]      head_data,
	output logic [4:0]                              entry_count,
	output logic                                    is_empty,
	output logic                                    overflow
);
	import spq_pkg::*;

	// Stored data keeps only the low DATA_WIDTH bits of the 32-bit field.
	localparam int SW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
	// Count must be able to hold CAPACITY itself.
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	logic              busy_q;
	logic              accept;
	logic              enq_go;
	logic              deq_go;
	logic [CW-1:0]     count_q;
	logic              done_q;
	logic [SW-1:0]     removed_data_q;
	logic              removed_valid_q;
	logic              overflow_q;

	// The chain: cell 0 is the head, entries are sorted by falling priority.
	logic [SW-1:0]                 cell_data [CAPACITY];
	logic signed [FIELD_W-1:0]     cell_prio [CAPACITY];
	logic [CAPACITY-1:0]           cell_keep;
	logic [CAPACITY-1:0]           cell_occ;

	assign accept = start && !busy_q;

	// A full queue drops an enqueue; an empty queue ignores a dequeue.
	// Both leave the chain untouched.
	assign enq_go = accept && (cmd == CMD_ENQUEUE) && (count_q != FULL_COUNT);
	assign deq_go = accept && (cmd == CMD_DEQUEUE) && (count_q != '0);

	// A cell is occupied when its position lies below the entry count.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_occ[i] = (CW'(i) < count_q);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int PI = (i == 0) ? 0 : i - 1;
		localparam int NI = (i == CAPACITY - 1) ? i : i + 1;
		cell_ctl_t ctl;

		assign ctl.enq       = enq_go;
		assign ctl.deq       = deq_go;
		// The head cell has nothing in front of it, so it behaves as if the
		// neighbor ahead always keeps its entry.
		assign ctl.prev_keep = (i == 0) ? 1'b1 : cell_keep[PI];

		spq_cell #(
			.SW(SW)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (cell_occ[i]),
			.new_data (item_data[SW-1:0]),
			.new_prio (item_priority),
			.prev_data(cell_data[PI]),
			.prev_prio(cell_prio[PI]),
			.next_data(cell_data[NI]),
			.next_prio(cell_prio[NI]),
			.keep     (cell_keep[i]),
			.data_q   (cell_data[i]),
			.prio_q   (cell_prio[i])
		);
	end

	// Control state: entry count, busy flag and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) begin
				case (cmd)
					CMD_ENQUEUE: begin
						if (enq_go) begin
							count_q <= count_q + CW'(1);
						end
					end
					CMD_DEQUEUE: begin
						if (deq_go) begin
							count_q <= count_q - CW'(1);
						end
					end
					CMD_CLEAR: begin
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
		end
	end

	// Result payload; captured on every accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_data_q  <= cell_data[0];
			removed_valid_q <= deq_go;
			overflow_q      <= (cmd == CMD_ENQUEUE) && (count_q == FULL_COUNT);
		end
	end

	// The head and count outputs read the chain after the update; they only
	// change at an accepted beat, so they hold through the strobe cycle.
	assign busy          = busy_q;
	assign done          = done_q;
	assign removed_data  = removed_valid_q ? FIELD_W'(removed_data_q) : NOTHING_WORD;
	assign removed_valid = removed_valid_q;
	assign head_data     = (count_q != '0) ? FIELD_W'(cell_data[0]) : NOTHING_WORD;
	assign entry_count   = 5'(count_q);
	assign is_empty      = (count_q == '0);
	assign overflow      = overflow_q;

	`SPQ_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > FULL_COUNT,
		"entry count exceeds capacity")
	`SPQ_ASSERT(a_done_follows, clk, arst_n, accept |=> done_q,
		"accepted beat produced no result strobe")
	`SPQ_ASSERT(a_ovf_full, clk, arst_n, (done_q && overflow_q) |-> (count_q == FULL_COUNT),
		"overflow reported while queue was not full")
	`SPQ_ASSERT(a_deq_count, clk, arst_n,
		(done_q && removed_valid_q) |-> (($past(count_q) - count_q) == CW'(1)),
		"dequeue did not lower the count by one")
	`SPQ_ASSERT(a_head_sorted, clk, arst_n,
		(count_q >= CW'(2)) |-> (cell_prio[0] >= cell_prio[1]),
		"head entry has lower priority than its successor")

endmodule

`default_nettype wire

/* test/tb_sorted_priority_queue_unit.sv */
// Self-checking testbench for sorted_priority_queue_unit: random and directed commands,
// with a shadow copy of the sorted queue that predicts each status beat.
// Depends on spq_pkg and the sorted_priority_queue_unit RTL only.
`default_nettype none

module tb_sorted_priority_queue_unit;

	import spq_pkg::*;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int RANDOM_CMDS = 700;

	// One command waiting to be driven, with the idle time the driver spends in
	// front of it and whether it must wait for the queue of status beats to empty.
	typedef struct {
		cmd_t                      op;
		logic signed [FIELD_W-1:0] data;
		logic signed [FIELD_W-1:0] prio;
		int                        gap;
		bit                        drain;
	} queue_cmd_t;

	// One status beat as the block reports it after a command.
	typedef struct {
		logic [FIELD_W-1:0] removed_data;
		logic               removed_valid;
		logic [FIELD_W-1:0] head_data;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic               overflow;
	} queue_status_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	cmd_t                      cmd = CMD_NOP;
	logic signed [FIELD_W-1:0] item_data = '0;
	logic signed [FIELD_W-1:0] item_priority = '0;
	logic                      done;
	logic signed [FIELD_W-1:0] removed_data;
	logic                      removed_valid;
	logic signed [FIELD_W-1:0] head_data;
	logic [4:0]                entry_count;
	logic                      is_empty;
	logic                      overflow;

	// Commands still to be driven, and status beats still to be seen, oldest first.
	queue_cmd_t    cmd_backlog[$];
	queue_status_t status_due[$];
	queue_cmd_t    live_cmd;

	// Shadow of the queue contents: slot 0 is the head.
	logic signed [FIELD_W-1:0] shadow_data[CAPACITY];
	logic signed [FIELD_W-1:0] shadow_prio[CAPACITY];
	int                        shadow_count = 0;

	int planned_count = 0;
	int accepted_count = 0;
	int fault_count = 0;
	int idle_cycles = 0;

	sorted_priority_queue_unit #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.item_data    (item_data),
		.item_priority(item_priority),
		.done         (done),
		.removed_data (removed_data),
		.removed_valid(removed_valid),
		.head_data    (head_data),
		.entry_count  (entry_count),
		.is_empty     (is_empty),
		.overflow     (overflow)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Applies one command to the shadow queue and returns the status beat that the
	// block must report for it. A new entry is placed behind every entry whose
	// priority is greater or equal, so equal priorities leave in arrival order.
	function automatic queue_status_t apply_queue_cmd(queue_cmd_t c);
		queue_status_t st;
		int pos;
		int i;
		st.removed_data  = NOTHING_WORD;
		st.removed_valid = 1'b0;
		st.overflow      = 1'b0;
		case (c.op)
			CMD_ENQUEUE: begin
				if (shadow_count >= CAPACITY) begin
					// A full queue drops the entry and leaves everything as it was.
					st.overflow = 1'b1;
				end else begin
					pos = 0;
					while (pos < shadow_count && shadow_prio[pos] >= c.prio)
						pos++;
					for (i = shadow_count; i > pos; i--) begin
						shadow_data[i] = shadow_data[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_data[pos] = c.data;
					shadow_prio[pos] = c.prio;
					shadow_count++;
				end
			end
			CMD_DEQUEUE: begin
				// Dequeue on an empty queue returns the all-ones word with valid low.
				if (shadow_count > 0) begin
					st.removed_data  = shadow_data[0];
					st.removed_valid = 1'b1;
					for (i = 1; i < shadow_count; i++) begin
						shadow_data[i-1] = shadow_data[i];
						shadow_prio[i-1] = shadow_prio[i];
					end
					shadow_count--;
				end
			end
			CMD_CLEAR: begin
				// Only the count goes to zero; slot contents stay behind.
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		st.head_data   = (shadow_count > 0) ? shadow_data[0] : NOTHING_WORD;
		st.entry_count = shadow_count[4:0];
		st.is_empty    = (shadow_count == 0);
		return st;
	endfunction

	task automatic add_cmd(cmd_t op, logic [FIELD_W-1:0] data, logic [FIELD_W-1:0] prio,
			int gap, bit drain);
		queue_cmd_t c;
		c.op    = op;
		c.data  = data;
		c.prio  = prio;
		c.gap   = gap;
		c.drain = drain;
		cmd_backlog.push_back(c);
	endtask

	task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Draws a priority: narrow ranges give many ties, the rest spans the full
	// range and its extremes.
	function automatic logic [FIELD_W-1:0] draw_priority();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 7);
			1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom_range(0, 3) - 2;
		endcase
	endfunction

	// Driver. A beat is taken at the edge where start is high and busy is low;
	// the shadow is updated right there. The next command goes out once its idle
	// gap has run, and, where marked, once every status beat has come back.
	always @(posedge clk or negedge arst_n) begin
		logic present;
		if (!arst_n) begin
			start         <= 1'b0;
			cmd           <= CMD_NOP;
			item_data     <= '0;
			item_priority <= '0;
			idle_cycles = 0;
		end else begin
			present = start;
			if (start && !busy) begin
				status_due.push_back(apply_queue_cmd(live_cmd));
				accepted_count++;
				present = 1'b0;
				idle_cycles = 0;
			end
			if (!present && cmd_backlog.size() > 0) begin
				if (idle_cycles >= cmd_backlog[0].gap &&
						(!cmd_backlog[0].drain || status_due.size() == 0)) begin
					live_cmd = cmd_backlog.pop_front();
					cmd           <= live_cmd.op;
					item_data     <= live_cmd.data;
					item_priority <= live_cmd.prio;
					present = 1'b1;
				end else begin
					idle_cycles++;
				end
			end
			start <= present;
		end
	end

	// Monitor. Every done beat is held against the oldest expected status; a beat
	// with nothing expected is a failure of its own.
	always @(posedge clk or negedge arst_n) begin
		queue_status_t want;
		if (!arst_n) begin
		end else if (done) begin
			if (status_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: status beat with no command outstanding", $realtime);
			end else begin
				want = status_due.pop_front();
				check_field("removed_data", want.removed_data, removed_data);
				check_field("removed_valid", 32'(want.removed_valid), 32'(removed_valid));
				check_field("head_data", want.head_data, head_data);
				check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
				check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
				check_field("overflow", 32'(want.overflow), 32'(overflow));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int n;
		int k;
		int bias;
		int roll;
		bit calm;
		int gap;
		cmd_t op;

		// Directed part: status and dequeue on an empty queue, a fill to capacity
		// with extreme words and priority ties, an enqueue into a full queue, a
		// dequeue from a full queue, clear, and a dequeue after clear.
		add_cmd(CMD_NOP, 32'h0, 32'h0, 0, 1'b0);
		add_cmd(CMD_DEQUEUE, 32'h0, 32'h0, 2, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h8000_0000, 32'h8000_0000, 0, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'hAAAA_AAAA, 32'h0000_0000, 0, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h5555_5555, 32'h7FFF_FFFF, 3, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h0000_0001, 32'hFFFF_FFFF, 0, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h0000_0002, 32'h8000_0000, 0, 1'b0);
		for (k = 0; k < 8; k++)
			add_cmd(CMD_ENQUEUE, 32'h100 + k, k % 3, k % 2, 1'b0);
		add_cmd(CMD_ENQUEUE, 32'h1234_5678, 32'h7FFF_FFFF, 0, 1'b0);
		add_cmd(CMD_DEQUEUE, 32'h0, 32'h0, 0, 1'b0);
		add_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		add_cmd(CMD_DEQUEUE, 32'h0, 32'h0, 0, 1'b0);
		add_cmd(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 1'b0);

		// Random part. The command mix swings between filling, draining and
		// balanced stretches so the queue keeps reaching both full and empty;
		// idle gaps come and go in stretches, some of them with no gaps at all.
		bias = 0;
		calm = 1'b0;
		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 40 == 0)
				bias = $urandom_range(0, 2);
			if (n % 55 == 0)
				calm = ($urandom_range(0, 2) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = CMD_CLEAR;
			else if (roll < 7)
				op = CMD_NOP;
			else if (bias == 0)
				op = (roll < 75) ? CMD_ENQUEUE : CMD_DEQUEUE;
			else if (bias == 1)
				op = (roll < 35) ? CMD_ENQUEUE : CMD_DEQUEUE;
			else
				op = (roll < 54) ? CMD_ENQUEUE : CMD_DEQUEUE;
			gap = calm ? 0 : $urandom_range(0, 15);
			// The first random command, and a few later ones, wait for the
			// block to report everything before they go out.
			add_cmd(op, $urandom, draw_priority(), gap,
				(n == 0) || ($urandom_range(0, 99) == 0));
		end
		planned_count = cmd_backlog.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < planned_count || status_due.size() != 0)
			@(posedge clk);
		// The extra edges below catch any stray beat.
		repeat (4) @(posedge clk);
		if (fault_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of this stimulus.
	initial begin
		#2400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
